### hdl/tie_pkg.sv
// Shared types and constants of the toy instruction executor.
// Instruction field codes, status codes and the structs between its modules.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tie_pkg;

    // Fixed field widths.
    localparam int INSTR_W    = 32;
    localparam int PARAM_W    = 5;
    localparam int DATA_W     = 32;
    localparam int OUT_PC_W   = 16;
    localparam int STAT_W     = 2;
    localparam int REG_IDX_W  = 5;
    localparam int OP_W       = 4;
    localparam int STEP_W     = $clog2(DATA_W);

    // Defaults of the top-level parameters.
    localparam int REG_COUNT_DEF = 32;
    localparam int PC_WIDTH_DEF  = 16;

    // Instruction types, bits 31:30.
    localparam logic [1:0] TY_R = 2'b00;
    localparam logic [1:0] TY_I = 2'b01;
    localparam logic [1:0] TY_J = 2'b10;
    localparam logic [1:0] TY_P = 2'b11;

    // Opcodes, bits 29:26.
    localparam logic [OP_W-1:0] OP_ADD   = 4'b0000;
    localparam logic [OP_W-1:0] OP_SUB   = 4'b0001;
    localparam logic [OP_W-1:0] OP_MUL   = 4'b0010;
    localparam logic [OP_W-1:0] OP_DIV   = 4'b0011;
    localparam logic [OP_W-1:0] OP_MOD   = 4'b0100;
    localparam logic [OP_W-1:0] OP_BEQ   = 4'b0101;
    localparam logic [OP_W-1:0] OP_BNE   = 4'b0110;
    localparam logic [OP_W-1:0] OP_MOVE  = 4'b0111;
    localparam logic [OP_W-1:0] OP_PRINT = 4'b1000;

    // Status codes reported with each result word.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADOP = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIVZ  = 2'd2;

    // Register file write request.
    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } t_rf_wr;

    // Request to the shared arithmetic unit.
    typedef struct packed {
        logic              start;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_alu_req;

    // Response of the shared arithmetic unit.
    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] res;
    } t_alu_rsp;

endpackage

`default_nettype wire

### hdl/tie_regfile.sv
// Register bank of the toy instruction executor: two registered read ports,
// one write port, per-entry valid bits that make unwritten entries read zero.
// Depends on tie_pkg.
`default_nettype none

module tie_regfile #(
    parameter int REG_COUNT = tie_pkg::REG_COUNT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_rd_en,
    input  wire logic [tie_pkg::REG_IDX_W-1:0]      i_rd_addr_a,
    input  wire logic [tie_pkg::REG_IDX_W-1:0]      i_rd_addr_b,
    output logic      [tie_pkg::DATA_W-1:0]         o_rd_data_a,
    output logic      [tie_pkg::DATA_W-1:0]         o_rd_data_b,
    input  wire tie_pkg::t_rf_wr                    i_wr
);
    import tie_pkg::*;

    localparam int IDX_W = $clog2(REG_COUNT);
    localparam logic [REG_IDX_W:0] COUNT = (REG_IDX_W + 1)'(REG_COUNT);

    logic [DATA_W-1:0]    r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [DATA_W-1:0]    r_data_a;
    logic [DATA_W-1:0]    r_data_b;
    logic                 r_ok_a;
    logic                 r_ok_b;

    logic in_a;
    logic in_b;
    logic in_w;

    // An index at or above the register count reads zero and ignores writes.
    assign in_a = {1'b0, i_rd_addr_a} < COUNT;
    assign in_b = {1'b0, i_rd_addr_b} < COUNT;
    assign in_w = {1'b0, i_wr.addr} < COUNT;

    // Storage array and its registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_wr.we && in_w) begin
            r_mem[i_wr.addr[IDX_W-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_data_a <= r_mem[i_rd_addr_a[IDX_W-1:0]];
            r_data_b <= r_mem[i_rd_addr_b[IDX_W-1:0]];
        end
    end

    // Valid bits mark entries written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ok_a <= 1'b0;
            r_ok_b <= 1'b0;
        end else begin
            if (i_wr.we && in_w) begin
                r_vld[i_wr.addr[IDX_W-1:0]] <= 1'b1;
            end
            if (i_rd_en) begin
                r_ok_a <= in_a && r_vld[i_rd_addr_a[IDX_W-1:0]];
                r_ok_b <= in_b && r_vld[i_rd_addr_b[IDX_W-1:0]];
            end
        end
    end

    assign o_rd_data_a = r_ok_a ? r_data_a : '0;
    assign o_rd_data_b = r_ok_b ? r_data_b : '0;

endmodule

`default_nettype wire

### hdl/tie_alu.sv
// Shared arithmetic unit: one 32-bit adder serves add, subtract, a 32-step
// shift-add multiply and a 32-step restoring signed divide and modulo.
// Depends on tie_pkg.
`default_nettype none

module tie_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tie_pkg::t_alu_req i_req,
    output tie_pkg::t_alu_rsp      o_rsp
);
    import tie_pkg::*;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_ADD  = 3'd1;
    localparam logic [2:0] A_MUL  = 3'd2;
    localparam logic [2:0] A_DIV  = 3'd3;
    localparam logic [2:0] A_FIX  = 3'd4;
    localparam logic [2:0] A_DONE = 3'd5;

    localparam logic [STEP_W-1:0] LAST_STEP = '1;

    logic [2:0]        r_state;
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_x;      // addend, product accumulator or partial remainder
    logic [DATA_W-1:0] r_y;      // addend, shifted multiplicand or divisor magnitude
    logic [DATA_W-1:0] r_z;      // multiplier or dividend shifting into quotient
    logic [STEP_W-1:0] r_cnt;
    logic              r_neg_q;
    logic              r_neg_r;
    logic [DATA_W-1:0] r_res;
    logic [STAT_W-1:0] r_stat;

    logic [DATA_W-1:0] add_x;
    logic [DATA_W-1:0] add_y;
    logic              add_sub;
    logic [DATA_W:0]   add_sum;
    logic [DATA_W-1:0] mul_acc;
    logic [DATA_W-1:0] rem_sh;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;

    // Operand selection for the shared adder.
    assign rem_sh = {r_x[DATA_W-2:0], r_z[DATA_W-1]};

    always_comb begin
        add_x   = r_x;
        add_y   = r_y;
        add_sub = 1'b0;
        case (r_state)
            A_ADD: begin
                add_sub = (r_op == OP_SUB);
            end
            A_DIV: begin
                add_x   = rem_sh;
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    // The shared adder; for a subtract the carry out means no borrow.
    assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {DATA_W{add_sub}}}
                   + (DATA_W + 1)'(add_sub);

    assign mul_acc = r_z[0] ? add_sum[DATA_W-1:0] : r_x;
    assign mag_a   = i_req.a[DATA_W-1] ? (~i_req.a + 1'b1) : i_req.a;
    assign mag_b   = i_req.b[DATA_W-1] ? (~i_req.b + 1'b1) : i_req.b;

    // Sequencer of the unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op   <= i_req.op;
                        r_stat <= ((i_req.op == OP_DIV || i_req.op == OP_MOD)
                                   && i_req.b == '0) ? ST_DIVZ : ST_OK;
                        r_res  <= '0;
                        r_cnt  <= '0;
                        case (i_req.op)
                            OP_ADD, OP_SUB: begin
                                r_x     <= i_req.a;
                                r_y     <= i_req.b;
                                r_state <= A_ADD;
                            end
                            OP_MUL: begin
                                r_x     <= '0;
                                r_y     <= i_req.a;
                                r_z     <= i_req.b;
                                r_state <= A_MUL;
                            end
                            OP_DIV, OP_MOD: begin
                                r_x     <= '0;
                                r_y     <= mag_b;
                                r_z     <= mag_a;
                                r_neg_q <= i_req.a[DATA_W-1] ^ i_req.b[DATA_W-1];
                                r_neg_r <= i_req.a[DATA_W-1];
                                if (i_req.b == '0) begin
                                    r_state <= A_DONE;
                                end else begin
                                    r_state <= A_DIV;
                                end
                            end
                            default: begin
                                r_state <= A_DONE;
                            end
                        endcase
                    end
                end
                A_ADD: begin
                    r_res   <= add_sum[DATA_W-1:0];
                    r_state <= A_DONE;
                end
                A_MUL: begin
                    // One multiplier bit per cycle; only the low word is kept.
                    r_x   <= mul_acc;
                    r_y   <= {r_y[DATA_W-2:0], 1'b0};
                    r_z   <= {1'b0, r_z[DATA_W-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_res   <= mul_acc;
                        r_state <= A_DONE;
                    end
                end
                A_DIV: begin
                    // One quotient bit per cycle on the magnitudes.
                    if (add_sum[DATA_W]) begin
                        r_x <= add_sum[DATA_W-1:0];
                    end else begin
                        r_x <= rem_sh;
                    end
                    r_z   <= {r_z[DATA_W-2:0], add_sum[DATA_W]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    // Signs follow truncation toward zero.
                    if (r_op == OP_DIV) begin
                        r_res <= r_neg_q ? (~r_z + 1'b1) : r_z;
                    end else begin
                        r_res <= r_neg_r ? (~r_x + 1'b1) : r_x;
                    end
                    r_state <= A_DONE;
                end
                A_DONE: begin
                    r_state <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = (r_state == A_DONE);
    assign o_rsp.status = r_stat;
    assign o_rsp.res    = r_res;

    // The divide loop never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == A_DIV) |-> (r_y != '0))
        else $error("divide loop running with zero divisor");

    // A divide-by-zero status only comes from a divide or modulo.
    a_divz_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.done && o_rsp.status == ST_DIVZ) |-> (r_op == OP_DIV || r_op == OP_MOD))
        else $error("divide-by-zero status on a non-divide operation");

    // Completion is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done)
        else $error("completion held for more than one cycle");

endmodule

`default_nettype wire

### hdl/toy_isa_instruction_executor_top.sv
// Top level of the toy instruction executor: sequencer, program counter,
// output register; instantiates tie_regfile and tie_alu, imports tie_pkg.
//
//   Channel  Direction  Handshake                 Word
//   in       input      i_in_valid / o_in_stall   i_instr_word, i_program_param
//   out      output     o_out_valid / i_out_stall o_next_pc, o_print_valid,
//                                                 o_print_value, o_status
//
// One instruction at a time: accept, register read, execute, commit.
// Jumps, branches, moves, prints, loads and bad opcodes skip the shared unit;
// add, subtract and a divide by zero pass through it without a loop;
// multiply, divide and modulo run the 32 steps of the shared adder; a commit
// also waits while the output register is full and not being taken.
// Reset is synchronous and active low; it clears the register bank's valid
// bits, the program counter and the sequencer at once.
`default_nettype none

module toy_isa_instruction_executor_top #(
    parameter int REG_COUNT = tie_pkg::REG_COUNT_DEF,
    parameter int PC_WIDTH  = tie_pkg::PC_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic        [tie_pkg::INSTR_W-1:0]  i_instr_word,
    input  wire logic        [tie_pkg::PARAM_W-1:0]  i_program_param,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic             [tie_pkg::OUT_PC_W-1:0] o_next_pc,
    output logic                                     o_print_valid,
    output logic signed      [tie_pkg::DATA_W-1:0]   o_print_value,
    output logic             [tie_pkg::STAT_W-1:0]   o_status
);
    import tie_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_ALU  = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    logic [1:0]          r_state;
    logic [PC_WIDTH-1:0] r_pc;
    logic [INSTR_W-1:0]  r_instr;
    logic [PARAM_W-1:0]  r_param;
    logic [PC_WIDTH-1:0] r_npc;
    logic [STAT_W-1:0]   r_status;
    logic                r_we;
    logic [DATA_W-1:0]   r_wdata;
    logic                r_pvalid;
    logic [DATA_W-1:0]   r_pvalue;
    logic                r_out_valid;
    logic [OUT_PC_W-1:0] r_out_pc;
    logic                r_out_pvalid;
    logic [DATA_W-1:0]   r_out_pvalue;
    logic [STAT_W-1:0]   r_out_status;

    logic [PC_WIDTH-1:0] n_npc;
    logic [STAT_W-1:0]   n_status;
    logic                n_we;
    logic [DATA_W-1:0]   n_wdata;
    logic                n_pvalid;
    logic [DATA_W-1:0]   n_pvalue;

    logic                 accept;
    logic                 out_free;
    logic                 commit;
    logic [REG_IDX_W-1:0] rd_addr_b;
    logic [DATA_W-1:0]    rf_a;
    logic [DATA_W-1:0]    rf_b;
    t_rf_wr               rf_wr;
    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;
    logic [1:0]           typ;
    logic [OP_W-1:0]      op;
    logic [PC_WIDTH-1:0]  pc_inc;
    logic                 alu_go;

    // Handshake and commit conditions.
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign commit   = (r_state == S_WB) && out_free;

    // Branches compare src1 with dest; everything else reads src1 and src2.
    assign rd_addr_b = (i_instr_word[29:26] == OP_BEQ || i_instr_word[29:26] == OP_BNE)
                     ? i_instr_word[25:21] : i_instr_word[15:11];

    assign rf_wr.we   = commit && r_we;
    assign rf_wr.addr = r_instr[25:21];
    assign rf_wr.data = r_wdata;

    tie_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr_a (i_instr_word[20:16]),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b),
        .i_wr        (rf_wr)
    );

    // Decode of the held instruction.
    assign typ    = r_instr[31:30];
    assign op     = r_instr[29:26];
    assign pc_inc = r_pc + 1'b1;

    // Arithmetic goes to the shared unit: R type ops add through modulo,
    // and the same five ops with the immediate in I type.
    always_comb begin
        alu_go = 1'b0;
        if (r_state == S_EXEC && (typ == TY_R || typ == TY_I)) begin
            alu_go = (op == OP_ADD || op == OP_SUB || op == OP_MUL
                   || op == OP_DIV || op == OP_MOD);
        end
    end

    // Outcome of every instruction that does not need the shared unit.
    always_comb begin
        n_npc    = pc_inc;
        n_status = ST_OK;
        n_we     = 1'b0;
        n_wdata  = rf_a;
        n_pvalid = 1'b0;
        n_pvalue = '0;
        if (typ == TY_J) begin
            n_npc = PC_WIDTH'(r_instr[29:0]);
        end else if (op > OP_PRINT) begin
            n_status = ST_BADOP;
        end else if (op inside {OP_BEQ, OP_BNE}) begin
            if ((op == OP_BEQ) == (rf_a == rf_b)) begin
                n_npc = PC_WIDTH'(r_instr[15:0]);
            end
        end else if (typ == TY_P) begin
            n_we    = 1'b1;
            n_wdata = DATA_W'(r_param);
        end else if (typ == TY_R && op == OP_MOVE) begin
            n_we = 1'b1;
        end else if (typ == TY_R && op == OP_PRINT) begin
            n_pvalid = 1'b1;
            n_pvalue = rf_a;
        end
    end

    assign alu_req.start = alu_go;
    assign alu_req.op    = op;
    assign alu_req.a     = rf_a;
    assign alu_req.b     = (typ == TY_R) ? rf_b : DATA_W'(r_instr[15:0]);

    tie_alu u_alu (
        .i_clk (i_clk),
        .i_rst_n (i_rst_n),
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Sequencer, program counter and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The result register fills at a commit and empties when taken.
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_instr <= i_instr_word;
                        r_param <= i_program_param;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_npc    <= n_npc;
                    r_status <= n_status;
                    r_we     <= n_we;
                    r_wdata  <= n_wdata;
                    r_pvalid <= n_pvalid;
                    r_pvalue <= n_pvalue;
                    r_state  <= alu_go ? S_ALU : S_WB;
                end
                S_ALU: begin
                    if (alu_rsp.done) begin
                        r_status <= alu_rsp.status;
                        r_we     <= (alu_rsp.status == ST_OK);
                        r_wdata  <= alu_rsp.res;
                        r_state  <= S_WB;
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        r_pc         <= r_npc;
                        r_out_pc     <= OUT_PC_W'(r_npc);
                        r_out_pvalid <= r_pvalid;
                        r_out_pvalue <= r_pvalue;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_out_pc;
    assign o_print_valid = r_out_pvalid;
    assign o_print_value = r_out_pvalue;
    assign o_status      = r_out_status;

    // An accepted word always moves on to execution.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted word did not enter execution");

    // A print never carries an error, and status stays within its codes.
    a_out_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == ST_OK || o_status == ST_BADOP
                          || o_status == ST_DIVZ)
                         && !(o_print_valid && o_status != ST_OK)))
        else $error("inconsistent result status");

    // The program counter only moves when a result is committed.
    a_pc_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !commit |=> $stable(r_pc))
        else $error("program counter changed without a commit");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the toy instruction executor top level.
// Holds an instruction-level predictor, the stimulus tests and the result checker.
// Depends on tie_pkg and toy_isa_instruction_executor_top.
`timescale 1ns / 100ps

module testbench;

    import tie_pkg::*;

    // Ring of expected words; only a few are ever outstanding.
    localparam int RQ_DEPTH = 64;

    // One retired instruction as seen on the output channel.
    typedef struct packed {
        logic [OUT_PC_W-1:0] next_pc;
        logic                print_valid;
        logic [DATA_W-1:0]   print_value;
        logic [STAT_W-1:0]   status;
    } t_retire;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [INSTR_W-1:0]    i_instr_word    = '0;
    logic [PARAM_W-1:0]    i_program_param = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [OUT_PC_W-1:0]   o_next_pc;
    logic                  o_print_valid;
    logic signed [DATA_W-1:0] o_print_value;
    logic [STAT_W-1:0]     o_status;

    // Architectural state of the predictor.
    logic [DATA_W-1:0]     arch_regs [REG_COUNT_DEF];
    logic [OUT_PC_W-1:0]   arch_pc;

    t_retire               retire_q [RQ_DEPTH];
    int                    rq_head         = 0;
    int                    rq_tail         = 0;
    int                    err_count       = 0;
    bit                    in_idle_en      = 1'b1;
    bit                    out_idle_en     = 1'b1;
    int                    out_hold_cycles = 0;

    toy_isa_instruction_executor_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_instr_word    (i_instr_word),
        .i_program_param (i_program_param),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_next_pc       (o_next_pc),
        .o_print_valid   (o_print_valid),
        .o_print_value   (o_print_value),
        .o_status        (o_status)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Signed arithmetic of the executor; division truncates toward zero.
    function automatic logic [STAT_W-1:0] alu_eval(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b,
                                                   output logic [DATA_W-1:0] res);
        longint sa;
        longint sb;
        res = '0;
        case (op)
            OP_ADD: res = a + b;
            OP_SUB: res = a - b;
            OP_MUL: res = a * b;
            OP_DIV, OP_MOD: begin
                if (b == '0) return ST_DIVZ;
                sa = $signed(a);
                sb = $signed(b);
                // Computed in 64 bits so the most negative value over minus one wraps.
                res = (op == OP_DIV) ? DATA_W'(sa / sb) : DATA_W'(sa % sb);
            end
            default: return ST_BADOP;
        endcase
        return ST_OK;
    endfunction

    // Executes one instruction on the predictor state and queues the expected word.
    task automatic isa_execute(input logic [INSTR_W-1:0] w, input logic [PARAM_W-1:0] p);
        logic [1:0]           ty;
        logic [OP_W-1:0]      op;
        logic [REG_IDX_W-1:0] rd;
        logic [REG_IDX_W-1:0] rs1;
        logic [REG_IDX_W-1:0] rs2;
        logic [15:0]          imm;
        logic [DATA_W-1:0]    res;
        t_retire              r;
        ty  = w[31:30];
        op  = w[29:26];
        rd  = w[25:21];
        rs1 = w[20:16];
        rs2 = w[15:11];
        imm = w[15:0];
        r = '0;
        r.next_pc = arch_pc + 1'b1;
        r.status  = ST_OK;
        if (ty == TY_J) begin
            r.next_pc = w[OUT_PC_W-1:0];
        end else if (op > OP_PRINT) begin
            r.status = ST_BADOP;
        end else if (op == OP_BEQ || op == OP_BNE) begin
            if ((op == OP_BEQ) == (arch_regs[rs1] == arch_regs[rd])) begin
                r.next_pc = imm;
            end
        end else if (ty == TY_P) begin
            arch_regs[rd] = DATA_W'(p);
        end else if (ty == TY_R && op == OP_MOVE) begin
            arch_regs[rd] = arch_regs[rs1];
        end else if (ty == TY_R && op == OP_PRINT) begin
            r.print_valid = 1'b1;
            r.print_value = arch_regs[rs1];
        end else if (ty == TY_R || op <= OP_MOD) begin
            // Immediate move and print fall through as no-ops.
            r.status = alu_eval(op, arch_regs[rs1],
                                (ty == TY_R) ? arch_regs[rs2] : DATA_W'(imm), res);
            if (r.status == ST_OK) arch_regs[rd] = res;
        end
        arch_pc = r.next_pc;
        retire_q[rq_tail % RQ_DEPTH] = r;
        rq_tail++;
    endtask

    function automatic logic [INSTR_W-1:0] mk_instr(input logic [1:0] ty,
                                                    input logic [OP_W-1:0] op,
                                                    input logic [REG_IDX_W-1:0] rd,
                                                    input logic [REG_IDX_W-1:0] rs1,
                                                    input logic [15:0] low);
        return {ty, op, rd, rs1, low};
    endfunction

    function automatic logic [INSTR_W-1:0] mk_r(input logic [OP_W-1:0] op,
                                                input logic [REG_IDX_W-1:0] rd,
                                                input logic [REG_IDX_W-1:0] rs1,
                                                input logic [REG_IDX_W-1:0] rs2);
        return mk_instr(TY_R, op, rd, rs1, {rs2, 11'h000});
    endfunction

    function automatic logic [PARAM_W-1:0] rand_param();
        return PARAM_W'($urandom_range(1, 31));
    endfunction

    // Mostly well-formed instructions over a few registers, with some raw noise.
    function automatic logic [INSTR_W-1:0] rand_instr();
        logic [INSTR_W-1:0] w;
        int                 sel;
        w   = $urandom();
        sel = $urandom_range(0, 19);
        if (sel < 19) begin
            w[31:30] = (sel < 7) ? TY_R : (sel < 12) ? TY_I : (sel < 16) ? TY_P : TY_J;
            if ($urandom_range(0, 7) != 0) w[29:26] = OP_W'($urandom_range(0, 8));
            if ($urandom_range(0, 3) != 0) begin
                w[25:21] = REG_IDX_W'($urandom_range(0, 7));
                w[20:16] = REG_IDX_W'($urandom_range(0, 7));
                w[15:11] = REG_IDX_W'($urandom_range(0, 7));
            end
        end
        return w;
    endfunction

    // Offers one word after a random gap and returns at the step it is accepted.
    task automatic send_word(input logic [INSTR_W-1:0] w, input logic [PARAM_W-1:0] p);
        int gap;
        gap = in_idle_en ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_instr_word    <= w;
        i_program_param <= p;
        isa_execute(w, p);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stops offering and waits until every expected word has come back.
    task automatic drain_retires();
        i_in_valid <= 1'b0;
        while (rq_tail != rq_head) @(posedge i_clk);
    endtask

    // Extremes, every operation and every special case, in a known order.
    task automatic test_directed();
        send_word(mk_instr(TY_P, OP_ADD, 5'd1, 5'd0, 16'h0000), 5'd31);
        send_word(mk_instr(TY_P, OP_PRINT, 5'd2, 5'd0, 16'h0000), 5'd1);
        send_word(mk_r(OP_ADD, 5'd3, 5'd1, 5'd2), rand_param());
        send_word(mk_r(OP_SUB, 5'd4, 5'd2, 5'd1), rand_param());
        send_word(mk_instr(TY_I, OP_MUL, 5'd5, 5'd1, 16'hFFFF), rand_param());
        send_word(mk_r(OP_MUL, 5'd6, 5'd5, 5'd5), rand_param());
        send_word(mk_instr(TY_I, OP_SUB, 5'd7, 5'd0, 16'h0001), rand_param());
        // Build the most negative value and divide it by minus one.
        send_word(mk_instr(TY_I, OP_MUL, 5'd8, 5'd2, 16'h8000), rand_param());
        send_word(mk_r(OP_MUL, 5'd8, 5'd8, 5'd8), rand_param());
        send_word(mk_r(OP_ADD, 5'd8, 5'd8, 5'd8), rand_param());
        send_word(mk_r(OP_DIV, 5'd9, 5'd8, 5'd7), rand_param());
        send_word(mk_r(OP_MOD, 5'd10, 5'd8, 5'd7), rand_param());
        // Negative dividends truncate toward zero.
        send_word(mk_instr(TY_I, OP_DIV, 5'd11, 5'd4, 16'h0007), rand_param());
        send_word(mk_instr(TY_I, OP_MOD, 5'd12, 5'd4, 16'h0007), rand_param());
        // Division by zero writes nothing.
        send_word(mk_r(OP_DIV, 5'd1, 5'd1, 5'd0), rand_param());
        send_word(mk_instr(TY_I, OP_MOD, 5'd1, 5'd1, 16'h0000), rand_param());
        send_word(mk_r(OP_MOVE, 5'd31, 5'd8, 5'd0), rand_param());
        send_word(mk_r(OP_PRINT, 5'd0, 5'd31, 5'd0), rand_param());
        send_word(mk_instr(TY_I, OP_MOVE, 5'd1, 5'd8, 16'hFFFF), rand_param());
        send_word(mk_instr(TY_I, OP_PRINT, 5'd1, 5'd8, 16'hFFFF), rand_param());
        // Branches taken in R and P type and not taken in I type; the top target wraps the PC.
        send_word(mk_instr(TY_R, OP_BEQ, 5'd1, 5'd1, 16'hFFFF), rand_param());
        send_word(mk_instr(TY_I, OP_BNE, 5'd1, 5'd1, 16'h0000), rand_param());
        send_word(mk_instr(TY_P, OP_BNE, 5'd1, 5'd2, 16'h1234), rand_param());
        send_word(mk_instr(TY_I, OP_BEQ, 5'd1, 5'd2, 16'h0000), rand_param());
        // Jumps to addresses wider than the counter.
        send_word({TY_J, 30'h3FFF_FFFF}, rand_param());
        send_word({TY_J, 30'h0000_0000}, rand_param());
        // Unknown opcodes in each type that decodes one.
        send_word(mk_r(4'hF, 5'd1, 5'd1, 5'd1), rand_param());
        send_word(mk_instr(TY_I, 4'h9, 5'd1, 5'd1, 16'hFFFF), rand_param());
        send_word(mk_instr(TY_P, 4'hC, 5'd1, 5'd1, 16'h0000), rand_param());
    endtask

    task automatic test_random(input int count);
        int n;
        for (n = 0; n < count; n++) send_word(rand_instr(), rand_param());
    endtask

    // The receiver holds off while words keep coming, so the input has to stall.
    task automatic test_backpressure();
        int n;
        in_idle_en      = 1'b0;
        out_hold_cycles = 100;
        for (n = 0; n < 16; n++) send_word(rand_instr(), rand_param());
        in_idle_en = 1'b1;
    endtask

    // The sender pauses until the block is empty before each burst.
    task automatic test_drain_pause();
        int round;
        for (round = 0; round < 3; round++) begin
            drain_retires();
            test_random(8);
        end
    endtask

    // A stretch with neither side idling.
    task automatic test_no_idle();
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        test_random(40);
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
    endtask

    // Receiver: a random stall before each word, or a long hold when one is requested.
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (out_hold_cycles > 0) begin
                n = out_hold_cycles;
                out_hold_cycles = 0;
            end else begin
                n = out_idle_en ? $urandom_range(0, 7) : 0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Compares each accepted result word with the oldest expected one.
    always @(posedge i_clk) begin : retire_check
        t_retire want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (rq_tail == rq_head) begin
                if (err_count < 10) $display("unexpected result word, pc %h", o_next_pc);
                err_count++;
            end else begin
                want = retire_q[rq_head % RQ_DEPTH];
                rq_head++;
                if (o_next_pc !== want.next_pc || o_print_valid !== want.print_valid ||
                    o_print_value !== want.print_value || o_status !== want.status) begin
                    if (err_count < 10) begin
                        $display("mismatch exp/act: pc %h/%h print %b/%b value %h/%h st %0d/%0d",
                                 want.next_pc, o_next_pc, want.print_valid, o_print_valid,
                                 want.print_value, o_print_value, want.status, o_status);
                    end
                    err_count++;
                end
            end
        end
    end

    // Upper bound on the whole run.
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        foreach (arch_regs[i]) arch_regs[i] = '0;
        arch_pc = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(200);
        test_backpressure();
        test_drain_pause();
        test_no_idle();
        test_random(200);

        // The wait after the drain gives a straggling word time to show up.
        drain_retires();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && rq_tail == rq_head) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
hdl/tie_pkg.sv
hdl/tie_regfile.sv
hdl/tie_alu.sv
hdl/toy_isa_instruction_executor_top.sv
tb/testbench.sv
